### rtl/date_interval_union_macros.svh
// Assertion macros for the date interval union block.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef DATE_INTERVAL_UNION_MACROS_SVH
`define DATE_INTERVAL_UNION_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DIU_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error("date_interval_union: check failed");

// antecedent implies consequent in the next cycle
`define DIU_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error("date_interval_union: check failed");

`endif

### rtl/dui_pkg.sv
// Shared types, constants and date arithmetic for the date interval union.
// No dependencies.
package dui_pkg;

  localparam int unsigned MaxIntervalsDef = 64;
  localparam int unsigned DateW = 23;
  localparam int unsigned EvW   = 24;
  localparam int unsigned YearW = 14;
  localparam int unsigned MonW  = 4;
  localparam int unsigned DayW  = 5;

  typedef struct packed {
    logic load;
    logic wr_start;
    logic wr_end;
    logic sort_init;
    logic rd_i;
    logic latch_v;
    logic rd_jm1;
    logic wr_v;
    logic shift;
    logic sw_init;
    logic rd_k;
    logic ev_proc;
    logic flush;
  } dui_cmd_t;

  typedef struct packed {
    logic room;
    logic last;
    logic i_done;
    logic j_zero;
    logic gt;
    logic k_done;
  } dui_stat_t;

  function automatic logic [DayW-1:0] month_len(input logic [YearW-1:0] y,
                                                input logic [MonW-1:0] m);
    logic [DayW-1:0] len;
    len = 5'd31;
    case (m)
      4'd2:                      len = (y[1:0] == 2'd0) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [DateW-1:0] next_day(input logic [DateW-1:0] date);
    logic [YearW-1:0] y;
    logic [MonW:0]    m;
    logic [DayW:0]    d;
    logic [DayW-1:0]  len;
    y   = date[22:9];
    m   = {1'b0, date[8:5]};
    d   = {1'b0, date[4:0]} + 6'd1;
    len = month_len(y, date[8:5]);
    if (d > {1'b0, len}) begin
      d = d - {1'b0, len};
      m = m + 5'd1;
      if (m > 5'd12) begin
        m = 5'd1;
        y = y + 14'd1;
      end
    end
    return {y, m[MonW-1:0], d[DayW-1:0]};
  endfunction

endpackage

### rtl/dui_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
module dui_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

### rtl/dui_ctrl.sv
// Controller for the date interval union: load, insertion sort, sweep.
// Depends on dui_pkg.
module dui_ctrl import dui_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  dui_stat_t stat_i,
  output dui_cmd_t  cmd_o,
  output logic      idle_o
);
  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StLd0  = 4'd1;
  localparam logic [3:0] StLd1  = 4'd2;
  localparam logic [3:0] StSrtI = 4'd3;
  localparam logic [3:0] StSrtV = 4'd4;
  localparam logic [3:0] StSrtJ = 4'd5;
  localparam logic [3:0] StSrtC = 4'd6;
  localparam logic [3:0] StSwRd = 4'd7;
  localparam logic [3:0] StSwEv = 4'd8;
  localparam logic [3:0] StFlsh = 4'd9;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = StLd0;
        end
      end
      StLd0: begin
        cmd_o.wr_start = stat_i.room;
        state_d        = StLd1;
      end
      StLd1: begin
        cmd_o.wr_end = stat_i.room;
        if (stat_i.last) begin
          cmd_o.sort_init = 1'b1;
          state_d         = StSrtI;
        end else begin
          state_d = StIdle;
        end
      end
      StSrtI: begin
        if (stat_i.i_done) begin
          cmd_o.sw_init = 1'b1;
          state_d       = StSwRd;
        end else begin
          cmd_o.rd_i = 1'b1;
          state_d    = StSrtV;
        end
      end
      StSrtV: begin
        cmd_o.latch_v = 1'b1;
        state_d       = StSrtJ;
      end
      StSrtJ: begin
        if (stat_i.j_zero) begin
          cmd_o.wr_v = 1'b1;
          state_d    = StSrtI;
        end else begin
          cmd_o.rd_jm1 = 1'b1;
          state_d      = StSrtC;
        end
      end
      StSrtC: begin
        // shift the larger entry up, or drop the held value into its slot
        if (stat_i.gt) begin
          cmd_o.shift = 1'b1;
          state_d     = StSrtJ;
        end else begin
          cmd_o.wr_v = 1'b1;
          state_d    = StSrtI;
        end
      end
      StSwRd: begin
        if (stat_i.k_done) begin
          state_d = StFlsh;
        end else begin
          cmd_o.rd_k = 1'b1;
          state_d    = StSwEv;
        end
      end
      StSwEv: begin
        cmd_o.ev_proc = 1'b1;
        state_d       = StSwRd;
      end
      StFlsh: begin
        cmd_o.flush = 1'b1;
        state_d     = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign idle_o = (state_q == StIdle);
endmodule

### rtl/dui_dp.sv
// Datapath for the date interval union: event store, counters, sweep, output.
// Depends on dui_pkg and dui_ram.
module dui_dp import dui_pkg::*; #(
  parameter int unsigned MaxIntervals = MaxIntervalsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dui_cmd_t         cmd_i,
  output dui_stat_t        stat_o,
  input  logic [YearW-1:0] start_year_i,
  input  logic [MonW-1:0]  start_month_i,
  input  logic [DayW-1:0]  start_day_i,
  input  logic [YearW-1:0] end_year_i,
  input  logic [MonW-1:0]  end_month_i,
  input  logic [DayW-1:0]  end_day_i,
  input  logic             last_i,
  output logic             valid_o,
  output logic [YearW-1:0] union_start_year_o,
  output logic [MonW-1:0]  union_start_month_o,
  output logic [DayW-1:0]  union_start_day_o,
  output logic [YearW-1:0] union_end_year_o,
  output logic [MonW-1:0]  union_end_month_o,
  output logic [DayW-1:0]  union_end_day_o,
  output logic             last_out_o
);
  localparam int unsigned Cap = 2 * MaxIntervals;
  localparam int unsigned AW  = $clog2(Cap);
  localparam int unsigned CW  = $clog2(Cap + 1);

  logic [CW-1:0]    count_q, i_q, j_q, k_q, depth_q;
  logic [CW-1:0]    count_p1, j_m1;
  logic [EvW-1:0]   ev_s_q, ev_e_q, v_q;
  logic             last_q;
  logic [DateW-1:0] run_q, hs_q, he_q;
  logic             hv_q;
  logic             out_v_q, out_last_q;
  logic [DateW-1:0] out_s_q, out_e_q;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [EvW-1:0]   wdata, rdata;
  logic [DateW-1:0] ev_date;
  logic             ev_end, joins, emit;

  assign count_p1 = count_q + CW'(1);
  assign j_m1     = j_q - CW'(1);
  assign ev_end   = rdata[0];
  assign ev_date  = rdata[EvW-1:1];
  assign joins    = hv_q && (next_day(he_q) == run_q);
  // a closing run that does not touch the held piece pushes the held piece out
  assign emit     = cmd_i.ev_proc && ev_end && (depth_q == CW'(1)) && hv_q && !joins;

  assign we    = cmd_i.wr_start | cmd_i.wr_end | cmd_i.wr_v | cmd_i.shift;
  assign waddr = cmd_i.wr_start ? count_q[AW-1:0] :
                 cmd_i.wr_end   ? count_p1[AW-1:0] : j_q[AW-1:0];
  assign wdata = cmd_i.wr_start ? ev_s_q :
                 cmd_i.wr_end   ? ev_e_q :
                 cmd_i.wr_v     ? v_q : rdata;
  assign raddr = cmd_i.rd_jm1 ? j_m1[AW-1:0] :
                 cmd_i.rd_k   ? k_q[AW-1:0] : i_q[AW-1:0];

  dui_ram #(.Width(EvW), .Depth(Cap)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign stat_o.room   = (count_q <= CW'(Cap - 2));
  assign stat_o.last   = last_q;
  assign stat_o.i_done = (i_q >= count_q);
  assign stat_o.j_zero = (j_q == '0);
  assign stat_o.gt     = (rdata > v_q);
  assign stat_o.k_done = (k_q >= count_q);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      depth_q <= '0;
      hv_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= emit | (cmd_i.flush & hv_q);
      if (cmd_i.wr_end) begin
        count_q <= count_q + CW'(2);
      end
      if (cmd_i.sw_init) begin
        depth_q <= '0;
        hv_q    <= 1'b0;
      end
      if (cmd_i.ev_proc) begin
        if (!ev_end) begin
          depth_q <= depth_q + CW'(1);
        end else if (depth_q != '0) begin
          depth_q <= depth_q - CW'(1);
          if (depth_q == CW'(1)) begin
            hv_q <= 1'b1;
          end
        end
      end
      if (cmd_i.flush) begin
        hv_q    <= 1'b0;
        count_q <= '0;
        depth_q <= '0;
      end
    end
  end

  // payload and walk indices
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ev_s_q <= {start_year_i, start_month_i, start_day_i, 1'b0};
      ev_e_q <= {end_year_i, end_month_i, end_day_i, 1'b1};
      last_q <= last_i;
    end
    if (cmd_i.sort_init) begin
      i_q <= CW'(1);
    end
    if (cmd_i.latch_v) begin
      v_q <= rdata;
      j_q <= i_q;
    end
    if (cmd_i.shift) begin
      j_q <= j_m1;
    end
    if (cmd_i.wr_v) begin
      i_q <= i_q + CW'(1);
    end
    if (cmd_i.sw_init) begin
      k_q <= '0;
    end
    if (cmd_i.ev_proc) begin
      k_q <= k_q + CW'(1);
      if (!ev_end) begin
        if (depth_q == '0) begin
          run_q <= ev_date;
        end
      end else if (depth_q == CW'(1)) begin
        if (joins) begin
          he_q <= ev_date;
        end else begin
          out_s_q    <= hs_q;
          out_e_q    <= he_q;
          out_last_q <= 1'b0;
          hs_q       <= run_q;
          he_q       <= ev_date;
        end
      end
    end
    if (cmd_i.flush) begin
      out_s_q    <= hs_q;
      out_e_q    <= he_q;
      out_last_q <= 1'b1;
    end
  end

  assign valid_o             = out_v_q;
  assign union_start_year_o  = out_s_q[22:9];
  assign union_start_month_o = out_s_q[8:5];
  assign union_start_day_o   = out_s_q[4:0];
  assign union_end_year_o    = out_e_q[22:9];
  assign union_end_month_o   = out_e_q[8:5];
  assign union_end_day_o     = out_e_q[4:0];
  assign last_out_o          = out_last_q;
endmodule

### rtl/date_interval_union.sv
// Date interval union. Loading an interval accepts it, then writes its two events.
// On the last interval the E stored events are insertion sorted through the single
// read port of the event RAM and then swept; results are strobed on valid_o, never in
// back-to-back cycles, the final one after the flush cycle. Results cannot be stalled.
// Reset clears controller, event count and strobe, not RAM.
module date_interval_union import dui_pkg::*; #(
  parameter int unsigned MaxIntervals = MaxIntervalsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [YearW-1:0] start_year_i,
  input  logic [MonW-1:0]  start_month_i,
  input  logic [DayW-1:0]  start_day_i,
  input  logic [YearW-1:0] end_year_i,
  input  logic [MonW-1:0]  end_month_i,
  input  logic [DayW-1:0]  end_day_i,
  input  logic             last_i,
  output logic             valid_o,
  output logic [YearW-1:0] union_start_year_o,
  output logic [MonW-1:0]  union_start_month_o,
  output logic [DayW-1:0]  union_start_day_o,
  output logic [YearW-1:0] union_end_year_o,
  output logic [MonW-1:0]  union_end_month_o,
  output logic [DayW-1:0]  union_end_day_o,
  output logic             last_out_o
);
  dui_cmd_t  cmd;
  dui_stat_t stat;
  logic      idle;

  dui_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start & ~busy),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .idle_o  (idle)
  );

  dui_dp #(.MaxIntervals(MaxIntervals)) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .start_year_i        (start_year_i),
    .start_month_i       (start_month_i),
    .start_day_i         (start_day_i),
    .end_year_i          (end_year_i),
    .end_month_i         (end_month_i),
    .end_day_i           (end_day_i),
    .last_i              (last_i),
    .valid_o             (valid_o),
    .union_start_year_o  (union_start_year_o),
    .union_start_month_o (union_start_month_o),
    .union_start_day_o   (union_start_day_o),
    .union_end_year_o    (union_end_year_o),
    .union_end_month_o   (union_end_month_o),
    .union_end_day_o     (union_end_day_o),
    .last_out_o          (last_out_o)
  );

  // hold busy while the final result is still on the ports
  assign busy = ~idle | valid_o;
endmodule

### rtl/dui_chk.sv
// Port checker for the date interval union, bound to the top level.
// Depends on date_interval_union_macros.svh.
`include "date_interval_union_macros.svh"
module dui_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic valid_o,
  input logic last_out_o
);
  `DIU_ASSERT_IMP(a_res_while_busy, valid_o, busy)
  `DIU_ASSERT_NXT(a_res_spaced, valid_o, !valid_o)
  `DIU_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `DIU_ASSERT_NXT(a_last_ends, valid_o && last_out_o, !valid_o)
endmodule

bind date_interval_union dui_chk u_dui_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .valid_o    (valid_o),
  .last_out_o (last_out_o)
);

### verif/date_interval_union_checker.sv
// Port checker for the date interval union: watches both channels, predicts
// the merged intervals of each batch and compares every strobed result.
// Depends on dui_pkg for the field widths.
module date_interval_union_checker import dui_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  logic [YearW-1:0] start_year_i,
  input  logic [MonW-1:0]  start_month_i,
  input  logic [DayW-1:0]  start_day_i,
  input  logic [YearW-1:0] end_year_i,
  input  logic [MonW-1:0]  end_month_i,
  input  logic [DayW-1:0]  end_day_i,
  input  logic             last_i,
  input  logic             valid_i,
  input  logic [YearW-1:0] union_start_year_i,
  input  logic [MonW-1:0]  union_start_month_i,
  input  logic [DayW-1:0]  union_start_day_i,
  input  logic [YearW-1:0] union_end_year_i,
  input  logic [MonW-1:0]  union_end_month_i,
  input  logic [DayW-1:0]  union_end_day_i,
  input  logic             last_out_i,
  output int unsigned      errors_o,
  output int unsigned      pending_o,
  output int unsigned      results_o
);

  localparam int unsigned EventCap = 2 * MaxIntervalsDef;

  typedef struct packed {
    logic [DateW-1:0] first_day;
    logic [DateW-1:0] last_day;
    logic             final_piece;
  } merged_t;

  logic [EvW-1:0] batch_events[$];
  merged_t        merged_q[$];

  assign pending_o = merged_q.size();

  function automatic logic [DayW-1:0] days_in_month(logic [YearW-1:0] y, logic [MonW-1:0] m);
    if (m == 4'd2) return (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
    if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) return 5'd30;
    return 5'd31;
  endfunction

  function automatic logic [DateW-1:0] day_after(logic [DateW-1:0] date);
    logic [YearW-1:0] y;
    int unsigned      m;
    int unsigned      d;
    int unsigned      len;
    y   = date[22:9];
    m   = date[8:5];
    d   = date[4:0] + 1;
    len = days_in_month(y, date[8:5]);
    if (d > len) begin
      d = d - len;
      m = m + 1;
      if (m > 12) begin
        m = 1;
        y = y + 1'b1;
      end
    end
    return {y, m[MonW-1:0], d[DayW-1:0]};
  endfunction

  // Sort the batch (start before end on a tie via the low bit), sweep it
  // with an open count and join pieces that touch day to day.
  task automatic merge_batch();
    logic [EvW-1:0]   v;
    logic [DateW-1:0] run_first;
    logic [DateW-1:0] date;
    merged_t          held;
    bit               held_ok;
    int unsigned      depth;
    int               j;
    for (int i = 1; i < batch_events.size(); i++) begin
      v = batch_events[i];
      j = i;
      while (j > 0 && batch_events[j-1] > v) begin
        batch_events[j] = batch_events[j-1];
        j--;
      end
      batch_events[j] = v;
    end
    depth     = 0;
    held_ok   = 1'b0;
    held      = '0;
    run_first = '0;
    foreach (batch_events[i]) begin
      date = batch_events[i][EvW-1:1];
      if (!batch_events[i][0]) begin
        if (depth == 0) run_first = date;
        depth++;
      end else if (depth != 0) begin
        depth--;
        if (depth == 0) begin
          if (held_ok && day_after(held.last_day) == run_first) begin
            held.last_day = date;
          end else begin
            if (held_ok) merged_q.push_back(held);
            held    = '{first_day: run_first, last_day: date, final_piece: 1'b0};
            held_ok = 1'b1;
          end
        end
      end
    end
    if (held_ok) begin
      held.final_piece = 1'b1;
      merged_q.push_back(held);
    end
    batch_events.delete();
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    merged_t want;
    if (!rst_ni) begin
      errors_o  = 0;
      results_o = 0;
    end else begin
      if (valid_i) begin
        results_o++;
        if (merged_q.size() == 0) begin
          report_mismatch("outstanding merged intervals", 1, 0);
        end else begin
          want = merged_q.pop_front();
          if (union_start_year_i != want.first_day[22:9])
            report_mismatch("union_start_year", union_start_year_i, want.first_day[22:9]);
          if (union_start_month_i != want.first_day[8:5])
            report_mismatch("union_start_month", union_start_month_i, want.first_day[8:5]);
          if (union_start_day_i != want.first_day[4:0])
            report_mismatch("union_start_day", union_start_day_i, want.first_day[4:0]);
          if (union_end_year_i != want.last_day[22:9])
            report_mismatch("union_end_year", union_end_year_i, want.last_day[22:9]);
          if (union_end_month_i != want.last_day[8:5])
            report_mismatch("union_end_month", union_end_month_i, want.last_day[8:5]);
          if (union_end_day_i != want.last_day[4:0])
            report_mismatch("union_end_day", union_end_day_i, want.last_day[4:0]);
          if (last_out_i != want.final_piece)
            report_mismatch("last_out", last_out_i, want.final_piece);
        end
      end
      if (start_i && !busy_i) begin
        // drop the interval once the store is full; its last flag still counts
        if (batch_events.size() + 2 <= EventCap) begin
          batch_events.push_back({start_year_i, start_month_i, start_day_i, 1'b0});
          batch_events.push_back({end_year_i, end_month_i, end_day_i, 1'b1});
        end
        if (last_i) merge_batch();
      end
    end
  end

endmodule

### verif/tb_date_interval_union.sv
// Testbench top for the date interval union: drives batches of intervals
// and gives the verdict. Depends on dui_pkg, date_interval_union and the checker.
module tb_date_interval_union;
  import dui_pkg::*;

  localparam int unsigned WatchdogLimit = 400000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [YearW-1:0] sy = '0, ey = '0;
  logic [MonW-1:0]  sm = 4'd1, em = 4'd1;
  logic [DayW-1:0]  sd = 5'd1, ed = 5'd1;
  logic             lst = 1'b0;
  logic             valid_o, last_out_o;
  logic [YearW-1:0] usy, uey;
  logic [MonW-1:0]  usm, uem;
  logic [DayW-1:0]  usd, ued;
  int unsigned      errors, pending, results;
  int unsigned      items = 0, batches = 0, idle_cycles = 0;
  bit               no_gaps = 1'b0;

  always #6 clk_i = ~clk_i;

  date_interval_union i_dut (
    .clk_i, .rst_ni, .start, .busy,
    .start_year_i(sy), .start_month_i(sm), .start_day_i(sd),
    .end_year_i(ey), .end_month_i(em), .end_day_i(ed), .last_i(lst),
    .valid_o,
    .union_start_year_o(usy), .union_start_month_o(usm), .union_start_day_o(usd),
    .union_end_year_o(uey), .union_end_month_o(uem), .union_end_day_o(ued),
    .last_out_o
  );

  date_interval_union_checker i_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy),
    .start_year_i(sy), .start_month_i(sm), .start_day_i(sd),
    .end_year_i(ey), .end_month_i(em), .end_day_i(ed), .last_i(lst),
    .valid_i(valid_o),
    .union_start_year_i(usy), .union_start_month_i(usm), .union_start_day_i(usd),
    .union_end_year_i(uey), .union_end_month_i(uem), .union_end_day_i(ued),
    .last_out_i(last_out_o),
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  // Count cycles with no transaction on either side; fail once the limit is reached.
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_interval(logic [DateW-1:0] first_day, logic [DateW-1:0] last_day,
                               logic is_last);
    if (!no_gaps && $urandom_range(0, 99) < 13) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start <= 1'b1;
    {sy, sm, sd} <= first_day;
    {ey, em, ed} <= last_day;
    lst <= is_last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items++;
    if (is_last) batches++;
  endtask

  // Hold off until every merged interval has come and the block is idle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (busy || pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [DateW-1:0] pick_date(logic [YearW-1:0] y, bit wild);
    logic [MonW-1:0] m;
    logic [DayW-1:0] d;
    m = wild ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 2));
    d = wild ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 31));
    return {y, m, d};
  endfunction

  task automatic random_batch(int unsigned n);
    logic [YearW-1:0] y;
    logic [DateW-1:0] a, b, t;
    bit               wild;
    y = 14'($urandom_range(0, 16383));
    for (int i = 0; i < n; i++) begin
      wild = ($urandom_range(0, 9) == 0);
      a = pick_date(wild ? 14'($urandom) : y, wild);
      b = pick_date(wild ? 14'($urandom) : y, wild);
      // keep most intervals well ordered, a few reversed
      if (a > b && $urandom_range(0, 4) != 0) begin
        t = a; a = b; b = t;
      end
      send_interval(a, b, i == n - 1);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // single day: the first valid date and the date with every field at its maximum
    send_interval({14'd0, 4'd1, 5'd1}, {14'd0, 4'd1, 5'd1}, 1'b1);
    send_interval({14'd16383, 4'd15, 5'd31}, {14'd16383, 4'd15, 5'd31}, 1'b1);
    // adjacent pieces across a common February and a year end; a leap February leaves a gap
    send_interval({14'd2001, 4'd2, 5'd10}, {14'd2001, 4'd2, 5'd28}, 1'b0);
    send_interval({14'd2001, 4'd3, 5'd1}, {14'd2001, 4'd3, 5'd5}, 1'b0);
    send_interval({14'd2004, 4'd2, 5'd1}, {14'd2004, 4'd2, 5'd28}, 1'b0);
    send_interval({14'd2004, 4'd3, 5'd1}, {14'd2004, 4'd3, 5'd2}, 1'b0);
    send_interval({14'd2004, 4'd12, 5'd20}, {14'd2004, 4'd12, 5'd31}, 1'b0);
    send_interval({14'd2005, 4'd1, 5'd1}, {14'd2005, 4'd1, 5'd3}, 1'b1);
    // year wrap, month outside range, day past the month length
    send_interval({14'd16383, 4'd12, 5'd1}, {14'd16383, 4'd12, 5'd31}, 1'b0);
    send_interval({14'd0, 4'd1, 5'd1}, {14'd0, 4'd1, 5'd9}, 1'b0);
    send_interval({14'd7, 4'd13, 5'd2}, {14'd7, 4'd13, 5'd31}, 1'b0);
    send_interval({14'd8, 4'd1, 5'd1}, {14'd8, 4'd1, 5'd2}, 1'b0);
    send_interval({14'd9, 4'd4, 5'd20}, {14'd9, 4'd4, 5'd31}, 1'b0);
    send_interval({14'd9, 4'd5, 5'd1}, {14'd9, 4'd5, 5'd4}, 1'b0);
    send_interval({14'd11, 4'd0, 5'd0}, {14'd11, 4'd0, 5'd5}, 1'b1);
    // equal dates: a start ties before an end; nesting and overlap
    send_interval({14'd50, 4'd6, 5'd1}, {14'd50, 4'd6, 5'd10}, 1'b0);
    send_interval({14'd50, 4'd6, 5'd10}, {14'd50, 4'd6, 5'd20}, 1'b0);
    send_interval({14'd50, 4'd6, 5'd3}, {14'd50, 4'd6, 5'd4}, 1'b0);
    send_interval({14'd50, 4'd6, 5'd22}, {14'd50, 4'd6, 5'd25}, 1'b1);
    // end before start only: no result; then mixed with a good one
    send_interval({14'd60, 4'd5, 5'd9}, {14'd60, 4'd5, 5'd1}, 1'b1);
    send_interval({14'd60, 4'd5, 5'd9}, {14'd60, 4'd5, 5'd1}, 1'b0);
    send_interval({14'd61, 4'd1, 5'd1}, {14'd61, 4'd1, 5'd2}, 1'b1);
    drain();

    // store full: the extra intervals are dropped, the last flag still ends it
    for (int i = 0; i < 68; i++)
      send_interval({14'd300, 4'($urandom_range(1, 12)), 5'(2 * i % 28 + 1)},
                    {14'd300, 4'd12, 5'($urandom_range(1, 31))}, i == 67);

    for (int b = 0; items < 160; b++) begin
      no_gaps = (b >= 2 && b < 8);
      random_batch($urandom_range(1, 8));
      if (b == 3) drain();
    end

    drain();
    repeat (50) @(posedge clk_i);
    $display("Sent %0d intervals in %0d batches; %0d merged intervals checked.",
             items, batches, results);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
